[hw/rtl/ip_address_text_validator_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the address text validator
// Clocked assertion helpers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef IP_ADDRESS_TEXT_VALIDATOR_MACROS_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every rising edge of clk, suppressed while rst_n is low.
`define IPAV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every rising edge of clk, reset included.
`define IPAV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IPAV_ASSERT(lbl, prop, msg)
`define IPAV_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hw/rtl/ipav_pkg.sv]
// ---------------------------------------------------------------------------
// Address text validator package
// Token type passed from the character decoder to the checker, and codes.
// ---------------------------------------------------------------------------
package ipav_pkg;

  // Result codes of address_class.
  localparam logic [1:0] CLASS_NEITHER = 2'd0;
  localparam logic [1:0] CLASS_IPV4    = 2'd1;
  localparam logic [1:0] CLASS_IPV6    = 2'd2;

  // Depth of the token queue between decoder and checker.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // IPv4 and IPv6 limits.
  localparam logic [1:0] V4_MAX_DOTS   = 2'd3;
  localparam logic [1:0] V4_MAX_DIGITS = 2'd3;
  localparam logic [2:0] V6_MAX_COLONS = 3'd7;
  localparam logic [2:0] V6_MAX_DIGITS = 3'd4;
  localparam logic [11:0] V4_MAX_VALUE = 12'd255;

  // One classified character.
  typedef struct packed {
    logic       has_char;
    logic       last;
    logic       is_dot;
    logic       is_colon;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] digit;
  } tok_t;

endpackage

[hw/rtl/ipav_if.sv]
// ---------------------------------------------------------------------------
// Address text validator channels
// Valid/ready channels for input characters and for result items.
// ---------------------------------------------------------------------------
interface ipav_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       has_char;
  logic       last;

  modport source (output valid, output character, output has_char, output last,
                  input ready);
  modport sink   (input valid, input character, input has_char, input last,
                  output ready);
endinterface

interface ipav_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] address_class;

  modport source (output valid, output address_class, input ready);
  modport sink   (input valid, input address_class, output ready);
endinterface

[hw/rtl/ipav_front.sv]
// ---------------------------------------------------------------------------
// Character decoder
// Accepts input items and turns each byte into a classified token.
// ---------------------------------------------------------------------------
module ipav_front (
  ipav_in_if.sink        in_ch,
  input  logic           q_full,
  output logic           q_push,
  output ipav_pkg::tok_t q_tok
);
  import ipav_pkg::*;

  logic [7:0] c;
  logic       dec;

  assign c   = in_ch.character;
  assign dec = (c >= 8'h30) && (c <= 8'h39);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_tok.has_char = in_ch.has_char;
    q_tok.last     = in_ch.last;
    q_tok.is_dot   = (c == 8'h2e);
    q_tok.is_colon = (c == 8'h3a);
    q_tok.is_dec   = dec;
    q_tok.is_hex   = dec || ((c >= 8'h61) && (c <= 8'h66)) ||
                     ((c >= 8'h41) && (c <= 8'h46));
    // Low nibble of an ASCII decimal digit is its value.
    q_tok.digit    = c[3:0];
  end

endmodule

[hw/rtl/ipav_queue.sv]
// ---------------------------------------------------------------------------
// Token queue
// Short first-in first-out buffer between the decoder and the checker.
// ---------------------------------------------------------------------------
module ipav_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ipav_pkg::tok_t push_tok,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ipav_pkg::tok_t head_tok
);
  import ipav_pkg::*;
`include "ip_address_text_validator_macros.svh"

  tok_t         mem_r [QDEPTH];
  logic [QAW:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0] count;

  assign count    = wr_ptr_r - rd_ptr_r;
  assign full     = (count == (QAW + 1)'(QDEPTH));
  assign empty    = (count == '0);
  assign head_tok = mem_r[rd_ptr_r[QAW-1:0]];

  assign wr_ptr_nxt = wr_ptr_r + (QAW + 1)'(push);
  assign rd_ptr_nxt = rd_ptr_r + (QAW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r[QAW-1:0]] <= push_tok;
    end
  end

  `IPAV_ASSERT(a_q_drain, (pop && !push) |=> (count == $past(count) - 1'b1), "queue drain lost count")
  `IPAV_ASSERT(a_q_no_underrun, pop |-> !empty, "pop from empty queue")

endmodule

[hw/rtl/ipav_back.sv]
// ---------------------------------------------------------------------------
// Address checker
// Runs the IPv4 and IPv6 checks on tokens and registers the result.
// ---------------------------------------------------------------------------
module ipav_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  ipav_pkg::tok_t tok,
  output logic           q_pop,
  ipav_out_if.source     out_ch
);
  import ipav_pkg::*;
`include "ip_address_text_validator_macros.svh"

  logic        v4_alive_r, v4_alive_nxt;
  logic [1:0]  v4_dots_r, v4_dots_nxt;
  logic [1:0]  v4_len_r, v4_len_nxt;
  logic [7:0]  v4_val_r, v4_val_nxt;
  logic        v4_lz_r, v4_lz_nxt;
  logic        v6_alive_r, v6_alive_nxt;
  logic [2:0]  v6_colons_r, v6_colons_nxt;
  logic [2:0]  v6_len_r, v6_len_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  class_r, class_nxt;
  logic        take;
  logic [11:0] v4_sum;

  // A queued token is taken when the result register is free or being emptied.
  assign take  = !q_empty && (!out_valid_r || out_ch.ready);
  assign q_pop = take;

  assign v4_sum = {1'b0, v4_val_r, 3'b000} + {3'b000, v4_val_r, 1'b0} + {8'd0, tok.digit};

  always_comb begin
    v4_alive_nxt  = v4_alive_r;
    v4_dots_nxt   = v4_dots_r;
    v4_len_nxt    = v4_len_r;
    v4_val_nxt    = v4_val_r;
    v4_lz_nxt     = v4_lz_r;
    v6_alive_nxt  = v6_alive_r;
    v6_colons_nxt = v6_colons_r;
    v6_len_nxt    = v6_len_r;

    if (take && tok.has_char && v4_alive_r) begin
      priority if (tok.is_dot) begin
        if ((v4_len_r == '0) || (v4_dots_r == V4_MAX_DOTS)) begin
          v4_alive_nxt = 1'b0;
        end else begin
          v4_dots_nxt = v4_dots_r + 2'd1;
          v4_len_nxt  = '0;
          v4_val_nxt  = '0;
          v4_lz_nxt   = 1'b0;
        end
      end else if (tok.is_dec) begin
        if ((v4_len_r == V4_MAX_DIGITS) || v4_lz_r || (v4_sum > V4_MAX_VALUE)) begin
          v4_alive_nxt = 1'b0;
        end else begin
          if ((v4_len_r == '0) && (tok.digit == '0)) begin
            v4_lz_nxt = 1'b1;
          end
          v4_val_nxt = v4_sum[7:0];
          v4_len_nxt = v4_len_r + 2'd1;
        end
      end else begin
        v4_alive_nxt = 1'b0;
      end
    end

    if (take && tok.has_char && v6_alive_r) begin
      priority if (tok.is_colon) begin
        if ((v6_len_r == '0) || (v6_colons_r == V6_MAX_COLONS)) begin
          v6_alive_nxt = 1'b0;
        end else begin
          v6_colons_nxt = v6_colons_r + 3'd1;
          v6_len_nxt    = '0;
        end
      end else if (tok.is_hex) begin
        if (v6_len_r == V6_MAX_DIGITS) begin
          v6_alive_nxt = 1'b0;
        end else begin
          v6_len_nxt = v6_len_r + 3'd1;
        end
      end else begin
        v6_alive_nxt = 1'b0;
      end
    end

    priority if (v4_alive_nxt && (v4_dots_nxt == V4_MAX_DOTS) && (v4_len_nxt != '0)) begin
      class_nxt = CLASS_IPV4;
    end else if (v6_alive_nxt && (v6_colons_nxt == V6_MAX_COLONS) && (v6_len_nxt != '0)) begin
      class_nxt = CLASS_IPV6;
    end else begin
      class_nxt = CLASS_NEITHER;
    end

    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (take && tok.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && tok.last)) begin
      v4_alive_r  <= 1'b1;
      v4_dots_r   <= '0;
      v4_len_r    <= '0;
      v4_val_r    <= '0;
      v4_lz_r     <= 1'b0;
      v6_alive_r  <= 1'b1;
      v6_colons_r <= '0;
      v6_len_r    <= '0;
    end else begin
      v4_alive_r  <= v4_alive_nxt;
      v4_dots_r   <= v4_dots_nxt;
      v4_len_r    <= v4_len_nxt;
      v4_val_r    <= v4_val_nxt;
      v4_lz_r     <= v4_lz_nxt;
      v6_alive_r  <= v6_alive_nxt;
      v6_colons_r <= v6_colons_nxt;
      v6_len_r    <= v6_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && tok.last) begin
      class_r <= class_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.address_class = class_r;

  `IPAV_ASSERT(a_last_gives_result, (take && tok.last) |=> out_valid_r,
               "last token gave no result")
  `IPAV_ASSERT(a_state_cleared,
               (take && tok.last) |=> (v4_len_r == '0 && v6_len_r == '0 &&
                                       v4_alive_r && v6_alive_r),
               "state not cleared after last")
  `IPAV_ASSERT(a_class_code,
               out_valid_r |-> (class_r == CLASS_NEITHER || class_r == CLASS_IPV4 ||
                                class_r == CLASS_IPV6),
               "undefined class code")

endmodule

[hw/rtl/ip_address_text_validator.sv]
// ---------------------------------------------------------------------------
// IP address text validator
// Classifies an ASCII address string as IPv4, IPv6 or neither.
// ---------------------------------------------------------------------------
// The block takes one character per clock cycle while the token queue has
// room, and gives one result item per string, registered by the checker
// after the item marked last has passed the queue. Throughput is one item
// every cycle unless a result waits at the output; the four-entry queue
// lets input flow for up to four items while that result is not taken.
module ip_address_text_validator (
  input  logic       clk,
  input  logic       rst_n,
  ipav_in_if.sink    in_ch,
  ipav_out_if.source out_ch
);
  import ipav_pkg::*;

  // The decoder pushes each accepted item into the queue as a token whose
  // character has already been sorted into dot, colon, decimal and hex.
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  tok_t push_tok;
  tok_t head_tok;

  ipav_front u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_tok    (push_tok)
  );

  // The queue decouples input acceptance from result backpressure.
  ipav_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_tok (head_tok)
  );

  // The checker keeps both address checks running and, on the last item of
  // a string, registers the class and returns its state to reset values.
  ipav_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .tok      (head_tok),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule

[verif/ip_address_text_validator_checker.sv]
// ---------------------------------------------------------------------------
// Address text validator checker
// Watches both channels, predicts the class of each finished string and
// compares every result item against the oldest prediction.
// ---------------------------------------------------------------------------
module ip_address_text_validator_checker
  import ipav_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ipav_in_if   in_ch,
  ipav_out_if  out_ch,
  output int   fail_count,
  output int   pending,
  output int   seen_neither,
  output int   seen_v4,
  output int   seen_v6
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  // Mirror of the block's scan state.
  logic       v4_ok;
  logic [1:0] dot_cnt;
  logic [1:0] dec_len;
  logic [7:0] dec_val;
  logic       dec_lead0;
  logic       v6_ok;
  logic [2:0] colon_cnt;
  logic [2:0] hex_len;

  logic [1:0] class_q[$];
  int errors;
  int n_neither, n_v4, n_v6;

  task automatic clear_scan();
    v4_ok     = 1'b1;
    dot_cnt   = '0;
    dec_len   = '0;
    dec_val   = '0;
    dec_lead0 = 1'b0;
    v6_ok     = 1'b1;
    colon_cnt = '0;
    hex_len   = '0;
  endtask

  task automatic scan_char(input logic [7:0] c);
    bit is_dec, is_hex;
    int sum;
    is_dec = (c >= CH_ZERO) && (c <= CH_NINE);
    is_hex = is_dec || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
             ((c >= CH_UP_A) && (c <= CH_UP_F));
    // Dotted-decimal side.
    if (v4_ok) begin
      if (c == CH_DOT) begin
        if (dec_len == 2'd0 || dot_cnt == 2'd3) begin
          v4_ok = 1'b0;
        end else begin
          dot_cnt   = dot_cnt + 2'd1;
          dec_len   = '0;
          dec_val   = '0;
          dec_lead0 = 1'b0;
        end
      end else if (is_dec) begin
        sum = int'(dec_val) * 10 + int'(c - CH_ZERO);
        if (dec_len == 2'd3 || dec_lead0 || sum > 255) begin
          v4_ok = 1'b0;
        end else begin
          if (dec_len == 2'd0 && c == CH_ZERO) dec_lead0 = 1'b1;
          dec_val = sum[7:0];
          dec_len = dec_len + 2'd1;
        end
      end else begin
        v4_ok = 1'b0;
      end
    end
    // Colon-hex side.
    if (v6_ok) begin
      if (c == CH_COLON) begin
        if (hex_len == 3'd0 || colon_cnt == 3'd7) begin
          v6_ok = 1'b0;
        end else begin
          colon_cnt = colon_cnt + 3'd1;
          hex_len   = '0;
        end
      end else if (is_hex) begin
        if (hex_len >= 3'd4) v6_ok = 1'b0;
        else hex_len = hex_len + 3'd1;
      end else begin
        v6_ok = 1'b0;
      end
    end
  endtask

  function automatic logic [1:0] judge_address();
    if (v4_ok && dot_cnt == 2'd3 && dec_len != 2'd0) return CLASS_IPV4;
    if (v6_ok && colon_cnt == 3'd7 && hex_len != 3'd0) return CLASS_IPV6;
    return CLASS_NEITHER;
  endfunction

  always @(posedge clk) begin
    logic [1:0] want;
    if (!rst_n) begin
      clear_scan();
      class_q.delete();
      errors    = 0;
      n_neither = 0;
      n_v4      = 0;
      n_v6      = 0;
    end else begin
      // Results leave before new strings are judged at the same edge.
      if (out_ch.valid && out_ch.ready) begin
        if (class_q.size() == 0) begin
          $display("%0t ns: result item with none expected: expected none, actual %0d",
                   $time, out_ch.address_class);
          errors++;
        end else begin
          want = class_q.pop_front();
          if (out_ch.address_class !== want) begin
            $display("%0t ns: address_class mismatch: expected %0d, actual %0d",
                     $time, want, out_ch.address_class);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.has_char) scan_char(in_ch.character);
        if (in_ch.last) begin
          want = judge_address();
          class_q.insert(class_q.size(), want);
          case (want)
            CLASS_IPV4: n_v4++;
            CLASS_IPV6: n_v6++;
            default:    n_neither++;
          endcase
          clear_scan();
        end
      end
    end
    fail_count   <= errors;
    pending      <= class_q.size();
    seen_neither <= n_neither;
    seen_v4      <= n_v4;
    seen_v6      <= n_v6;
  end

endmodule

[verif/ip_address_text_validator_tb.sv]
// ---------------------------------------------------------------------------
// Address text validator testbench
// Feeds directed and random address strings through the validator with
// bursty input and a stalling receiver, and lets the checker judge results.
// ---------------------------------------------------------------------------
module ip_address_text_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One item on the input channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       fin;
  } char_item_t;

  localparam int ITEM_TARGET = 1800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ipav_in_if  in_ch();
  ipav_out_if out_ch();

  int fail_count, pending, seen_neither, seen_v4, seen_v6;

  ip_address_text_validator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ip_address_text_validator_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .seen_neither (seen_neither),
    .seen_v4      (seen_v4),
    .seen_v6      (seen_v6)
  );

  always #2 clk = ~clk;

  // Text of the string under construction, and the item stream built from it.
  byte unsigned text[$];
  char_item_t   feed_q[$];
  int           strings_built = 0;
  int           items_sent = 0;

  string hex_set   = "0123456789abcdefABCDEF";
  string noise_set = "0123456789.:abcdefABCDEFxgG ";

  // Append one byte to the end of the text.
  task automatic put_byte(input byte unsigned b);
    text.insert(text.size(), b);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_dec(input int v);
    put_str($sformatf("%0d", v));
  endtask

  // Dotted-decimal candidate. A flawed one may carry a wrong group count,
  // leading zeros, values past 255, four-digit groups or empty groups.
  task automatic add_v4(input bit flawed);
    int groups, kind;
    groups = 4;
    if (flawed && $urandom_range(0, 2) == 0) groups = $urandom_range(3, 5);
    for (int g = 0; g < groups; g++) begin
      if (g > 0) put_byte(8'h2E);
      kind = (flawed && $urandom_range(0, 2) == 0) ? $urandom_range(10, 13)
                                                   : $urandom_range(0, 5);
      case (kind)
        0:       put_dec(0);
        1:       put_dec(255);
        2:       put_dec($urandom_range(0, 9));
        3:       put_dec($urandom_range(10, 99));
        10:      begin put_dec(0); put_dec($urandom_range(0, 99)); end
        11:      put_dec($urandom_range(256, 999));
        12:      put_dec($urandom_range(1000, 9999));
        13:      ;
        default: put_dec($urandom_range(0, 255));
      endcase
    end
  endtask

  // Colon-hex candidate. A flawed one may carry seven or nine groups,
  // empty groups or five-digit groups.
  task automatic add_v6(input bit flawed);
    int groups, len;
    groups = 8;
    if (flawed && $urandom_range(0, 2) == 0) groups = $urandom_range(7, 9);
    for (int g = 0; g < groups; g++) begin
      if (g > 0) put_byte(8'h3A);
      if (flawed && $urandom_range(0, 3) == 0) len = ($urandom_range(0, 1) != 0) ? 5 : 0;
      else len = $urandom_range(1, 4);
      for (int k = 0; k < len; k++) put_byte(hex_set[$urandom_range(0, 21)]);
    end
  endtask

  task automatic add_noise();
    int len;
    len = $urandom_range(0, 16);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 1) != 0) put_byte(8'($urandom_range(0, 255)));
      else put_byte(noise_set[$urandom_range(0, noise_set.len() - 1)]);
    end
  endtask

  // Replace, drop or insert one byte anywhere in the text.
  task automatic mangle();
    int pos;
    if (text.size() == 0) return;
    pos = $urandom_range(0, text.size() - 1);
    case ($urandom_range(0, 2))
      0:       text[pos] = byte'($urandom_range(0, 255));
      1:       text.delete(pos);
      default: text.insert(pos, noise_set[$urandom_range(0, noise_set.len() - 1)]);
    endcase
  endtask

  // Turn the text into items. Empty items with a random byte are sprinkled
  // in, and the string sometimes ends on an empty item marked last.
  task automatic emit_text();
    char_item_t it;
    bit tail;
    tail = (text.size() == 0) || ($urandom_range(0, 4) == 0);
    for (int i = 0; i < text.size(); i++) begin
      if ($urandom_range(0, 9) == 0) begin
        it.ch = 8'($urandom_range(0, 255)); it.has = 1'b0; it.fin = 1'b0;
        feed_q.insert(feed_q.size(), it);
      end
      it.ch = text[i]; it.has = 1'b1; it.fin = !tail && (i == text.size() - 1);
      feed_q.insert(feed_q.size(), it);
    end
    if (tail) begin
      it.ch = 8'($urandom_range(0, 255)); it.has = 1'b0; it.fin = 1'b1;
      feed_q.insert(feed_q.size(), it);
    end
    text.delete();
    strings_built++;
  endtask

  task automatic add_literal(input string s);
    put_str(s);
    emit_text();
  endtask

  // Receiver: switches between random stall patterns, and twice
  // holds off for a long stretch so the token queue fills and input stalls.
  initial begin
    int cycle, hold, mode;
    out_ch.ready = 1'b0;
    cycle = 0;
    hold  = 0;
    mode  = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      cycle++;
      if (cycle % 64 == 0) mode = $urandom_range(0, 3);
      if (cycle == 400) hold = 250;
      if (cycle == 1500) hold = 120;
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) != 0);
          2:       out_ch.ready <= (cycle % 4 == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
      @(posedge clk);
    end
  end

  // Sender and verdict.
  initial begin
    char_item_t cur;
    int burst, gap, pick;
    in_ch.valid     = 1'b0;
    in_ch.character = 8'h00;
    in_ch.has_char  = 1'b0;
    in_ch.last      = 1'b0;

    // Directed strings: empty, extremes, and each way a string can fail.
    add_literal("");
    add_literal("255.255.255.255");
    add_literal("0.0.0.0");
    add_literal("256.1.1.1");
    add_literal("01.2.3.4");
    add_literal("1000.1.1.1");
    add_literal("1..2.3");
    add_literal(".1.2.3");
    add_literal("1.2.3.4.5");
    add_literal("ffff:FFFF:aBcD:0:1:2:3:9");
    add_literal("1:2:3:4:5:6:7:8:9");
    add_literal("12345:1:1:1:1:1:1:1");
    add_literal("1::2:3:4:5:6:7");
    add_literal("1:2:3:4:5:6:7:");
    add_literal("g:1:1:1:1:1:1:1");
    put_str("1.2.3.");
    put_byte(8'hFF);
    emit_text();
    put_str("1.2.3.4");
    put_byte(8'h80);
    emit_text();

    // Random strings, most of them well formed so both scanners get deep.
    while (feed_q.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 33) add_v4(1'b0);
      else if (pick < 63) add_v6(1'b0);
      else if (pick < 75) add_v4(1'b1);
      else if (pick < 87) add_v6(1'b1);
      else if (pick < 96) add_noise();
      if (pick >= 63 && pick < 87 && $urandom_range(0, 2) == 0) mangle();
      emit_text();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bursts of random length; a zero gap keeps valid high across bursts.
    while (feed_q.size() != 0) begin
      burst = $urandom_range(1, 48);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      while (burst > 0 && feed_q.size() != 0) begin
        cur = feed_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.character <= cur.ch;
        in_ch.has_char  <= cur.has;
        in_ch.last      <= cur.fin;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
        burst--;
      end
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    // The checker's counters are registered, so step once before polling.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d strings in %0d items, with random input gaps and output stalls.",
             strings_built, items_sent);
    $display("Results checked: %0d IPv4, %0d IPv6, %0d neither.",
             seen_v4, seen_v6, seen_neither);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Timed out with %0d results still expected.", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
